// ===== src/lprot_pkg.sv =====
// Shared constants and types for the last-pressed route override table.
`timescale 1ns / 1ps

package lprot_pkg;

  // Table geometry
  localparam int unsigned Entries      = 8;
  localparam int unsigned IdxW         = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int unsigned PositionBits = 8;
  localparam int unsigned RouteBits    = 4;
  localparam int unsigned StampBits    = 32;

  // Stream payload widths
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 8;

  // Event kinds carried in the input tuser bit
  localparam logic FuncPress   = 1'b0;
  localparam logic FuncRelease = 1'b1;

  // Result status codes
  localparam logic StatusOk   = 1'b0;
  localparam logic StatusFull = 1'b1;

  typedef logic [IdxW-1:0]         idx_t;
  typedef logic [PositionBits-1:0] pos_t;
  typedef logic [RouteBits-1:0]    route_t;
  typedef logic [StampBits-1:0]    stamp_t;

endpackage

// ===== src/last_pressed_route_override_table_top.sv =====
// Top level of the last-pressed route override table with its scan sequencer.
//
// Usage: key events enter on the s_axis channel, one beat per event. tuser is
// the event kind (press or release), tdata carries the key position and the
// route to hold while pressed. Each event gives exactly one result beat on the
// m_axis channel: status (ok or table full), whether any override is active,
// and the route of the most recently pressed active key (0 when none).
// Sequence: after accept, one index counter walks the eight entries twice
// through the shared compare path: once to find the matching or lowest free
// entry, then StWrite updates the entry, then it walks once more to pick the
// highest stamp, then StDone hands the result to the output register.
// s_axis_tready is high only while the sequencer is idle, so one event is at
// work at a time and the next is not taken before StDone is left. The output
// register holds a result while the receiver stalls and a new event may be
// accepted meanwhile; that event waits at its last step until the register
// is free.
// Reset clears all active marks, the order counter and the output valid.
`timescale 1ns / 1ps

module last_pressed_route_override_table_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Input events
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic                           s_axis_tuser,   // [0] func
  input  logic [lprot_pkg::InDataW-1:0]  s_axis_tdata,   // [7:0] key_position,
                                                         // [11:8] route_index
  // Results
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [lprot_pkg::OutDataW-1:0] m_axis_tdata    // [0] status,
                                                         // [1] override_valid,
                                                         // [5:2] selected_route
);

  // Sequencer codes
  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StScan  = 3'd1;
  localparam logic [2:0] StWrite = 3'd2;
  localparam logic [2:0] StSel   = 3'd3;
  localparam logic [2:0] StDone  = 3'd4;

  localparam lprot_pkg::idx_t LastIdx = lprot_pkg::idx_t'(lprot_pkg::Entries - 1);

  logic [2:0] state_q, state_d;
  lprot_pkg::idx_t idx_q, idx_d;

  // Latched event
  logic              func_q;
  lprot_pkg::pos_t   key_q;
  lprot_pkg::route_t route_in_q;

  // Table storage
  logic [lprot_pkg::Entries-1:0] active_q, active_d;
  lprot_pkg::pos_t   pos_q   [lprot_pkg::Entries];
  lprot_pkg::route_t route_q [lprot_pkg::Entries];
  lprot_pkg::stamp_t stamp_q [lprot_pkg::Entries];
  lprot_pkg::stamp_t counter_q, counter_d;

  // Search results
  logic            match_found_q, match_found_d;
  lprot_pkg::idx_t match_idx_q, match_idx_d;
  logic            free_found_q, free_found_d;
  lprot_pkg::idx_t free_idx_q, free_idx_d;
  logic            status_q, status_d;

  // Selection results
  logic              best_found_q, best_found_d;
  lprot_pkg::stamp_t best_stamp_q, best_stamp_d;
  lprot_pkg::route_t best_route_q, best_route_d;

  // Output register
  logic                           out_valid_q, out_valid_d;
  logic [lprot_pkg::OutDataW-1:0] out_data_q, out_data_d;

  // Table write port
  logic              wr_en;
  lprot_pkg::idx_t   wr_idx;

  // Shared compare path on the entry under the index counter
  logic pos_eq, stamp_gt;
  assign pos_eq   = active_q[idx_q] && (pos_q[idx_q] == key_q);
  assign stamp_gt = stamp_q[idx_q] > best_stamp_q;

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Sequencer and datapath control
  always_comb begin
    state_d       = state_q;
    idx_d         = idx_q;
    active_d      = active_q;
    counter_d     = counter_q;
    match_found_d = match_found_q;
    match_idx_d   = match_idx_q;
    free_found_d  = free_found_q;
    free_idx_d    = free_idx_q;
    status_d      = status_q;
    best_found_d  = best_found_q;
    best_stamp_d  = best_stamp_q;
    best_route_d  = best_route_q;
    out_valid_d   = out_valid_q;
    out_data_d    = out_data_q;
    wr_en         = 1'b0;
    wr_idx        = free_idx_q;

    // Drop the result once the receiver takes it
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (s_axis_tvalid) begin
          state_d       = StScan;
          idx_d         = '0;
          match_found_d = 1'b0;
          free_found_d  = 1'b0;
        end
      end
      StScan: begin
        // Record the first match and the lowest free entry
        if (pos_eq && !match_found_q) begin
          match_found_d = 1'b1;
          match_idx_d   = idx_q;
        end
        if (!active_q[idx_q] && !free_found_q) begin
          free_found_d = 1'b1;
          free_idx_d   = idx_q;
        end
        if (idx_q == LastIdx) begin
          state_d = StWrite;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      StWrite: begin
        status_d = lprot_pkg::StatusOk;
        if (func_q == lprot_pkg::FuncPress) begin
          if (match_found_q || free_found_q) begin
            wr_en     = 1'b1;
            wr_idx    = match_found_q ? match_idx_q : free_idx_q;
            counter_d = counter_q + 1'b1;
            active_d[wr_idx] = 1'b1;
          end else begin
            status_d = lprot_pkg::StatusFull;
          end
        end else if (match_found_q) begin
          active_d[match_idx_q] = 1'b0;
        end
        state_d      = StSel;
        idx_d        = '0;
        best_found_d = 1'b0;
        best_stamp_d = '0;
        best_route_d = '0;
      end
      StSel: begin
        // Keep the lowest entry with the highest stamp
        if (active_q[idx_q] && (!best_found_q || stamp_gt)) begin
          best_found_d = 1'b1;
          best_stamp_d = stamp_q[idx_q];
          best_route_d = route_q[idx_q];
        end
        if (idx_q == LastIdx) begin
          state_d = StDone;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      StDone: begin
        // Hold until the output register is free
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = lprot_pkg::OutDataW'({best_route_q, best_found_q, status_q});
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      active_q    <= '0;
      counter_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      counter_q   <= counter_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    idx_q         <= idx_d;
    match_found_q <= match_found_d;
    match_idx_q   <= match_idx_d;
    free_found_q  <= free_found_d;
    free_idx_q    <= free_idx_d;
    status_q      <= status_d;
    best_found_q  <= best_found_d;
    best_stamp_q  <= best_stamp_d;
    best_route_q  <= best_route_d;
    out_data_q    <= out_data_d;
    if (s_axis_tvalid && s_axis_tready) begin
      func_q     <= s_axis_tuser;
      key_q      <= s_axis_tdata[lprot_pkg::PositionBits-1:0];
      route_in_q <= s_axis_tdata[lprot_pkg::PositionBits +: lprot_pkg::RouteBits];
    end
  end

  // Entry payload: position, route and stamp of the chosen entry
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      pos_q[wr_idx]   <= key_q;
      route_q[wr_idx] <= route_in_q;
      stamp_q[wr_idx] <= counter_d;
    end
  end

endmodule
